/* rtl/segment_pick_hit_test_macros.svh */
// Assertion macros shared by the segment pick hit test design.
`ifndef SEGMENT_PICK_HIT_TEST_MACROS_SVH
`define SEGMENT_PICK_HIT_TEST_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SEG_PICK_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SEG_PICK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEG_PICK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/seg_pick_pkg.sv */
// Types and constants of the segment pick hit test.
`timescale 1ns / 1ps
package seg_pick_pkg;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_Z = 1'b0,
    CFG_PICK_TOL = 1'b1
  } cfg_reg_e;

  // Which point of the projected segment is nearest to the query point.
  typedef enum logic [1:0] {
    SEL_NEAR_MAX = 2'd0,
    SEL_FIRST    = 2'd1,
    SEL_SECOND   = 2'd2,
    SEL_INTERP   = 2'd3
  } sel_e;

  typedef enum logic [1:0] {
    OBUF_EMPTY = 2'd0,
    OBUF_ONE   = 2'd1,
    OBUF_FULL  = 2'd2
  } obuf_cnt_e;

endpackage

/* rtl/seg_pick_if.sv */
// Valid/ready channel interfaces for segment words and result words.
`timescale 1ns / 1ps
interface seg_pick_in_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] end1_x;
  logic signed [W-1:0] end1_y;
  logic signed [W-1:0] end1_z;
  logic signed [W-1:0] end2_x;
  logic signed [W-1:0] end2_y;
  logic signed [W-1:0] end2_z;
  logic signed [W-1:0] query_x;
  logic signed [W-1:0] query_y;
  modport source (output valid, end1_x, end1_y, end1_z, end2_x, end2_y, end2_z,
                  query_x, query_y, input ready);
  modport sink (input valid, end1_x, end1_y, end1_z, end2_x, end2_y, end2_z,
                query_x, query_y, output ready);
endinterface

interface seg_pick_out_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic hit;
  logic behind_camera;
  logic signed [W-1:0] hit_depth;
  modport source (output valid, hit, behind_camera, hit_depth, input ready);
  modport sink (input valid, hit, behind_camera, hit_depth, output ready);
endinterface

/* rtl/seg_pick_proj.sv */
// Pipelined perspective divide of one coordinate, one quotient bit per stage.
`timescale 1ns / 1ps
module seg_pick_proj #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] coord_i,
  input  logic        [W-1:0] depth_i,
  output logic signed [W-1:0] proj_o
);

  localparam int NB = W + 2 + F;
  localparam int CB = 2 * W + F + 2;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic          neg;
  logic [W-1:0]  magc;
  logic [NB-1:0] num;
  logic [NB-1:0] num_sh;
  logic [CB-1:0] thr;

  logic [W-1:0] s0_r_q, s0_low_q, s0_d_q;
  logic         s0_neg_q, s0_sat_q;

  logic [W-1:0] r_q   [W];
  logic [W-1:0] low_q [W];
  logic [W-1:0] q_q   [W];
  logic [W-1:0] d_q   [W];
  logic         neg_q [W];
  logic         sat_q [W];

  logic [W-1:0] r_in   [W];
  logic [W-1:0] low_in [W];
  logic [W-1:0] q_in   [W];
  logic [W-1:0] d_in   [W];
  logic         neg_in [W];
  logic         sat_in [W];

  logic [W-1:0] mag_fin;
  logic [W-1:0] proj_q;

  // The quotient is below 2^W whenever it is not saturated, so the top of the
  // shifted numerator is already a valid partial remainder.
  always_comb begin
    neg    = coord_i[W-1];
    magc   = neg ? W'(-coord_i) : W'(coord_i);
    num    = {magc, 2'b00, {F{1'b0}}};
    num_sh = num >> W;
    thr    = (CB'(depth_i) << (W - 1)) + (neg ? CB'(depth_i) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_r_q   <= num_sh[W-1:0];
      s0_low_q <= num[W-1:0];
      s0_d_q   <= depth_i;
      s0_neg_q <= neg;
      s0_sat_q <= CB'(num) >= thr;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] r2;
    logic       ge;

    if (k == 0) begin : g_first
      assign r_in[k]   = s0_r_q;
      assign low_in[k] = s0_low_q;
      assign q_in[k]   = '0;
      assign d_in[k]   = s0_d_q;
      assign neg_in[k] = s0_neg_q;
      assign sat_in[k] = s0_sat_q;
    end else begin : g_next
      assign r_in[k]   = r_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign q_in[k]   = q_q[k-1];
      assign d_in[k]   = d_q[k-1];
      assign neg_in[k] = neg_q[k-1];
      assign sat_in[k] = sat_q[k-1];
    end

    assign r2 = {r_in[k], low_in[k][W-1]};
    assign ge = r2 >= {1'b0, d_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? W'(r2 - {1'b0, d_in[k]}) : r2[W-1:0];
        low_q[k] <= low_in[k] << 1;
        q_q[k]   <= {q_in[k][W-2:0], ge};
        d_q[k]   <= d_in[k];
        neg_q[k] <= neg_in[k];
        sat_q[k] <= sat_in[k];
      end
    end
  end

  always_comb begin
    if (sat_q[W-1]) begin
      mag_fin = neg_q[W-1] ? LIM_NEG : LIM_POS;
    end else begin
      mag_fin = q_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      proj_q <= neg_q[W-1] ? W'(-mag_fin) : mag_fin;
    end
  end

  assign proj_o = $signed(proj_q);

endmodule

/* rtl/seg_pick_tdiv.sv */
// Pipelined fraction divider for the segment parameter, one bit per stage.
`timescale 1ns / 1ps
module seg_pick_tdiv #(
  parameter int DW = 66,
  parameter int F  = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [F-1:0]  quot_o
);

  logic [DW-1:0] r_q  [F];
  logic [DW-1:0] d_q  [F];
  logic [F-1:0]  q_q  [F];
  logic [DW-1:0] r_in [F];
  logic [DW-1:0] d_in [F];
  logic [F-1:0]  q_in [F];

  for (genvar k = 0; k < F; k++) begin : g_step
    logic [DW:0] r2;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in[k] = num_i;
      assign d_in[k] = den_i;
      assign q_in[k] = '0;
    end else begin : g_next
      assign r_in[k] = r_q[k-1];
      assign d_in[k] = d_q[k-1];
      assign q_in[k] = q_q[k-1];
    end

    assign r2 = {r_in[k], 1'b0};
    assign ge = r2 >= {1'b0, d_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? DW'(r2 - {1'b0, d_in[k]}) : r2[DW-1:0];
        d_q[k] <= d_in[k];
        q_q[k] <= (q_in[k] << 1) | F'(ge);
      end
    end
  end

  assign quot_o = q_q[F-1];

endmodule

/* rtl/seg_pick_obuf.sv */
// Two-word output buffer that decouples the pipeline from the result channel.
`timescale 1ns / 1ps
`include "segment_pick_hit_test_macros.svh"
module seg_pick_obuf import seg_pick_pkg::*; #(
  parameter int DW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  logic [DW-1:0] push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output logic [DW-1:0] pop_data_o,
  input  logic          pop_ready_i
);

  obuf_cnt_e     cnt_q, cnt_d;
  logic [DW-1:0] head_q, skid_q;
  logic          push, pop;
  logic          load_head, load_skid, head_from_skid;

  assign push_ready_o = cnt_q != OBUF_FULL;
  assign pop_valid_o  = cnt_q != OBUF_EMPTY;
  assign pop_data_o   = head_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    case (cnt_q)
      OBUF_EMPTY: begin
        if (push) cnt_d = OBUF_ONE;
      end
      OBUF_ONE: begin
        if (pop && !push) begin
          cnt_d = OBUF_EMPTY;
        end else if (push && !pop) begin
          cnt_d = OBUF_FULL;
        end
      end
      OBUF_FULL: begin
        if (pop) cnt_d = OBUF_ONE;
      end
      default: cnt_d = OBUF_EMPTY;
    endcase
  end

  always_comb begin
    load_head      = 1'b0;
    load_skid      = 1'b0;
    head_from_skid = 1'b0;
    case (cnt_q)
      OBUF_EMPTY: load_head = push;
      OBUF_ONE: begin
        load_head = push && pop;
        load_skid = push && !pop;
      end
      OBUF_FULL: head_from_skid = pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= OBUF_EMPTY;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_head) begin
      head_q <= push_data_i;
    end else if (head_from_skid) begin
      head_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= push_data_i;
    end
  end

  `SEG_PICK_ASSERT(a_cnt_legal, cnt_q == OBUF_EMPTY || cnt_q == OBUF_ONE || cnt_q == OBUF_FULL, "bad count")
  `SEG_PICK_ASSERT_IMP(a_full_blocks_push, cnt_q == OBUF_FULL, !push_ready_o, "push while full")
  `SEG_PICK_ASSERT_NXT(a_skid_fills, cnt_q == OBUF_ONE && push && !pop, cnt_q == OBUF_FULL && skid_q == $past(push_data_i), "skid word lost")

endmodule

/* rtl/segment_pick_hit_test.sv */
// Top level of the segment pick hit test pipeline.
//
//   channel   direction  handshake          word
//   seg_i     in         valid/ready        two 3D endpoints and a 2D query point
//   res_o     out        valid/ready        hit, behind_camera, hit_depth
//   cfg_*     in         cfg_we_i strobe    camera_z or pick_tolerance
//
// One segment word is taken per cycle unless the output buffer is full; the path runs
// through the two bit-per-stage divider pipelines.
// Reset clears valid bits, the output buffer and the registers (tolerance 1.0).
// The output buffer holds two words, so the pipeline keeps moving while a result
// waits; it stops as a whole only when both buffer slots are occupied.
`timescale 1ns / 1ps
`include "segment_pick_hit_test_macros.svh"
module segment_pick_hit_test import seg_pick_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  seg_pick_in_if.sink            seg_i,
  seg_pick_out_if.source         res_o
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PL = W + 2;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;
  localparam int DW = 2 * W + 2;
  localparam int MW = F + W + 2;
  localparam int OW = W + 2;
  localparam logic [W:0]       SMALL_D    = (W+1)'(((1 << F) + 500) / 1000);
  localparam logic [W-2:0]     TOL_RESET  = (W-1)'(1) << F;
  localparam logic [2*W-3:0]   TOL2_RESET = (2*W-2)'(1) << (2 * F);

  typedef struct packed {
    logic                behind;
    logic signed [W-1:0] z1;
    logic signed [W-1:0] z2;
    logic signed [W-1:0] qx;
    logic signed [W-1:0] qy;
  } side_t;

  typedef struct packed {
    sel_e                sel;
    side_t               side;
    logic signed [W-1:0] px1;
    logic signed [W-1:0] py1;
    logic signed [W-1:0] px2;
    logic signed [W-1:0] py2;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic signed [W:0]   dz;
  } mid_t;

  // Configuration registers.
  logic signed [W-1:0] cam_q;
  logic [W-2:0]        tol_q;
  logic [2*W-3:0]      tol2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q  <= '0;
      tol_q  <= TOL_RESET;
      tol2_q <= TOL2_RESET;
    end else begin
      tol2_q <= {{(W-1){1'b0}}, tol_q} * {{(W-1){1'b0}}, tol_q};
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CAMERA_Z: cam_q <= $signed(cfg_data_i);
          CFG_PICK_TOL: tol_q <= cfg_data_i[W-2:0];
          default: ;
        endcase
      end
    end
  end

  logic en;

  assign seg_i.ready = en;

  // Stage A: input register, depth offsets and the behind-camera test.
  logic signed [W:0] zt1, zt2;
  logic [W:0]        nzt1, nzt2;

  logic                a_valid_q;
  side_t               a_side_q;
  logic signed [W-1:0] a_x1_q, a_y1_q, a_x2_q, a_y2_q;
  logic [W-1:0]        a_d1_q, a_d2_q;

  always_comb begin
    zt1  = (W+1)'(seg_i.end1_z) - (W+1)'(cam_q);
    zt2  = (W+1)'(seg_i.end2_z) - (W+1)'(cam_q);
    nzt1 = -zt1;
    nzt2 = -zt2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= seg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q.behind <= seg_i.end1_z >= cam_q || seg_i.end2_z >= cam_q;
      a_side_q.z1     <= seg_i.end1_z;
      a_side_q.z2     <= seg_i.end2_z;
      a_side_q.qx     <= seg_i.query_x;
      a_side_q.qy     <= seg_i.query_y;
      a_x1_q          <= seg_i.end1_x;
      a_y1_q          <= seg_i.end1_y;
      a_x2_q          <= seg_i.end2_x;
      a_y2_q          <= seg_i.end2_y;
      a_d1_q          <= nzt1[W-1:0];
      a_d2_q          <= nzt2[W-1:0];
    end
  end

  // Projection dividers and the matching side-data delay line.
  logic signed [W-1:0] px1, py1, px2, py2;

  seg_pick_proj #(.W(W), .F(F)) u_proj_x1 (
    .clk_i(clk_i), .en_i(en), .coord_i(a_x1_q), .depth_i(a_d1_q), .proj_o(px1));
  seg_pick_proj #(.W(W), .F(F)) u_proj_y1 (
    .clk_i(clk_i), .en_i(en), .coord_i(a_y1_q), .depth_i(a_d1_q), .proj_o(py1));
  seg_pick_proj #(.W(W), .F(F)) u_proj_x2 (
    .clk_i(clk_i), .en_i(en), .coord_i(a_x2_q), .depth_i(a_d2_q), .proj_o(px2));
  seg_pick_proj #(.W(W), .F(F)) u_proj_y2 (
    .clk_i(clk_i), .en_i(en), .coord_i(a_y2_q), .depth_i(a_d2_q), .proj_o(py2));

  logic  pv_q [PL];
  side_t ps_q [PL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PL; k++) pv_q[k] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= a_valid_q;
      for (int k = 1; k < PL; k++) pv_q[k] <= pv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= a_side_q;
      for (int k = 1; k < PL; k++) ps_q[k] <= ps_q[k-1];
    end
  end

  // Stage B: segment direction and query offset.
  logic                b_valid_q;
  side_t               b_side_q;
  logic signed [W-1:0] b_px1_q, b_py1_q, b_px2_q, b_py2_q;
  logic signed [W:0]   b_dx_q, b_dy_q, b_ax_q, b_ay_q, b_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= pv_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= ps_q[PL-1];
      b_px1_q  <= px1;
      b_py1_q  <= py1;
      b_px2_q  <= px2;
      b_py2_q  <= py2;
      b_dx_q   <= (W+1)'(px2) - (W+1)'(px1);
      b_dy_q   <= (W+1)'(py2) - (W+1)'(py1);
      b_ax_q   <= (W+1)'(ps_q[PL-1].qx) - (W+1)'(px1);
      b_ay_q   <= (W+1)'(ps_q[PL-1].qy) - (W+1)'(py1);
      b_dz_q   <= (W+1)'(ps_q[PL-1].z2) - (W+1)'(ps_q[PL-1].z1);
    end
  end

  // Stage C: dot products and the coincident-ends test.
  logic [W:0] adx, ady;

  logic                c_valid_q;
  side_t               c_side_q;
  logic signed [W-1:0] c_px1_q, c_py1_q, c_px2_q, c_py2_q;
  logic signed [W:0]   c_dx_q, c_dy_q, c_dz_q;
  logic                c_small_q;
  logic signed [PW-1:0] c_mnx_q, c_mny_q, c_mdx_q, c_mdy_q;

  always_comb begin
    adx = b_dx_q[W] ? (W+1)'(-b_dx_q) : b_dx_q;
    ady = b_dy_q[W] ? (W+1)'(-b_dy_q) : b_dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q  <= b_side_q;
      c_px1_q   <= b_px1_q;
      c_py1_q   <= b_py1_q;
      c_px2_q   <= b_px2_q;
      c_py2_q   <= b_py2_q;
      c_dx_q    <= b_dx_q;
      c_dy_q    <= b_dy_q;
      c_dz_q    <= b_dz_q;
      c_small_q <= (adx < SMALL_D && ady < SMALL_D) || (b_dx_q == '0 && b_dy_q == '0);
      c_mnx_q   <= b_ax_q * b_dx_q;
      c_mny_q   <= b_ay_q * b_dy_q;
      c_mdx_q   <= b_dx_q * b_dx_q;
      c_mdy_q   <= b_dy_q * b_dy_q;
    end
  end

  // Stage D: numerator and denominator of the segment parameter.
  logic                d_valid_q;
  side_t               d_side_q;
  logic signed [W-1:0] d_px1_q, d_py1_q, d_px2_q, d_py2_q;
  logic signed [W:0]   d_dx_q, d_dy_q, d_dz_q;
  logic                d_small_q;
  logic signed [NW-1:0] d_num_q, d_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q  <= c_side_q;
      d_px1_q   <= c_px1_q;
      d_py1_q   <= c_py1_q;
      d_px2_q   <= c_px2_q;
      d_py2_q   <= c_py2_q;
      d_dx_q    <= c_dx_q;
      d_dy_q    <= c_dy_q;
      d_dz_q    <= c_dz_q;
      d_small_q <= c_small_q;
      d_num_q   <= NW'(c_mnx_q) + NW'(c_mny_q);
      d_den_q   <= NW'(c_mdx_q) + NW'(c_mdy_q);
    end
  end

  // Stage E: clamp decision; the divider only matters for interior points.
  sel_e sel;

  always_comb begin
    if (d_small_q) begin
      sel = SEL_NEAR_MAX;
    end else if (d_num_q[NW-1] || d_num_q == '0) begin
      sel = SEL_FIRST;
    end else if (d_num_q >= d_den_q) begin
      sel = SEL_SECOND;
    end else begin
      sel = SEL_INTERP;
    end
  end

  logic          e_valid_q;
  mid_t          e_mid_q;
  logic [DW-1:0] e_num_q, e_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_mid_q.sel  <= sel;
      e_mid_q.side <= d_side_q;
      e_mid_q.px1  <= d_px1_q;
      e_mid_q.py1  <= d_py1_q;
      e_mid_q.px2  <= d_px2_q;
      e_mid_q.py2  <= d_py2_q;
      e_mid_q.dx   <= d_dx_q;
      e_mid_q.dy   <= d_dy_q;
      e_mid_q.dz   <= d_dz_q;
      e_num_q      <= d_num_q[DW-1:0];
      e_den_q      <= d_den_q[DW-1:0];
    end
  end

  logic [F-1:0] t;

  seg_pick_tdiv #(.DW(DW), .F(F)) u_tdiv (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (e_num_q),
    .den_i  (e_den_q),
    .quot_o (t)
  );

  logic tv_q [F];
  mid_t tm_q [F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < F; k++) tv_q[k] <= 1'b0;
    end else if (en) begin
      tv_q[0] <= e_valid_q;
      for (int k = 1; k < F; k++) tv_q[k] <= tv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tm_q[0] <= e_mid_q;
      for (int k = 1; k < F; k++) tm_q[k] <= tm_q[k-1];
    end
  end

  // Stage M: scale the direction and depth span by the parameter.
  logic                 m_valid_q;
  mid_t                 m_mid_q;
  logic signed [MW-1:0] m_tx_q, m_ty_q, m_tz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= tv_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mid_q <= tm_q[F-1];
      m_tx_q  <= $signed({1'b0, t}) * tm_q[F-1].dx;
      m_ty_q  <= $signed({1'b0, t}) * tm_q[F-1].dy;
      m_tz_q  <= $signed({1'b0, t}) * tm_q[F-1].dz;
    end
  end

  // Stage N: nearest point and its depth.
  logic signed [MW-1:0] sx, sy, sz;
  logic [W:0]           vx_sum, vy_sum, vz_sum;
  logic signed [W-1:0]  vx, vy, vdepth, zmax;

  always_comb begin
    sx     = m_tx_q >>> F;
    sy     = m_ty_q >>> F;
    sz     = m_tz_q >>> F;
    vx_sum = (W+1)'(m_mid_q.px1) + sx[W:0];
    vy_sum = (W+1)'(m_mid_q.py1) + sy[W:0];
    vz_sum = (W+1)'(m_mid_q.side.z1) + sz[W:0];
    zmax   = (m_mid_q.side.z1 > m_mid_q.side.z2) ? m_mid_q.side.z1 : m_mid_q.side.z2;
    case (m_mid_q.sel)
      SEL_NEAR_MAX: begin
        vx     = m_mid_q.px1;
        vy     = m_mid_q.py1;
        vdepth = zmax;
      end
      SEL_SECOND: begin
        vx     = m_mid_q.px2;
        vy     = m_mid_q.py2;
        vdepth = m_mid_q.side.z2;
      end
      SEL_INTERP: begin
        vx     = $signed(vx_sum[W-1:0]);
        vy     = $signed(vy_sum[W-1:0]);
        vdepth = $signed(vz_sum[W-1:0]);
      end
      default: begin
        vx     = m_mid_q.px1;
        vy     = m_mid_q.py1;
        vdepth = m_mid_q.side.z1;
      end
    endcase
  end

  logic                n_valid_q, n_behind_q;
  logic signed [W-1:0] n_qx_q, n_qy_q, n_vx_q, n_vy_q, n_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (en) begin
      n_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_behind_q <= m_mid_q.side.behind;
      n_qx_q     <= m_mid_q.side.qx;
      n_qy_q     <= m_mid_q.side.qy;
      n_vx_q     <= vx;
      n_vy_q     <= vy;
      n_depth_q  <= vdepth;
    end
  end

  // Stage Q: offset from the nearest point to the query point.
  logic                q_valid_q, q_behind_q;
  logic signed [W-1:0] q_depth_q;
  logic signed [W:0]   q_ex_q, q_ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (en) begin
      q_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_behind_q <= n_behind_q;
      q_depth_q  <= n_depth_q;
      q_ex_q     <= (W+1)'(n_qx_q) - (W+1)'(n_vx_q);
      q_ey_q     <= (W+1)'(n_qy_q) - (W+1)'(n_vy_q);
    end
  end

  // Stage R: squared offsets.
  logic                 r_valid_q, r_behind_q;
  logic signed [W-1:0]  r_depth_q;
  logic signed [PW-1:0] r_sx_q, r_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= q_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_behind_q <= q_behind_q;
      r_depth_q  <= q_depth_q;
      r_sx_q     <= q_ex_q * q_ex_q;
      r_sy_q     <= q_ey_q * q_ey_q;
    end
  end

  // Distance test and result word.
  logic [PW:0]   dist_sq;
  logic          hit;
  logic [W-1:0]  depth_out;
  logic [OW-1:0] out_word;

  always_comb begin
    dist_sq   = {1'b0, r_sx_q} + {1'b0, r_sy_q};
    hit       = !r_behind_q && (dist_sq < (PW+1)'(tol2_q));
    depth_out = r_behind_q ? '0 : r_depth_q;
    out_word  = {hit, r_behind_q, depth_out};
  end

  logic [OW-1:0] res_word;

  seg_pick_obuf #(.DW(OW)) u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (r_valid_q),
    .push_data_i  (out_word),
    .push_ready_o (en),
    .pop_valid_o  (res_o.valid),
    .pop_data_o   (res_word),
    .pop_ready_i  (res_o.ready)
  );

  assign res_o.hit           = res_word[OW-1];
  assign res_o.behind_camera = res_word[OW-2];
  assign res_o.hit_depth     = $signed(res_word[W-1:0]);

  `SEG_PICK_ASSERT_IMP(a_behind_clean, res_o.valid && res_o.behind_camera, !res_o.hit && res_o.hit_depth == '0, "behind-camera word not cleared")
  `SEG_PICK_ASSERT_IMP(a_interp_range, e_valid_q && e_mid_q.sel == SEL_INTERP, e_num_q < e_den_q && e_num_q != '0, "interior point outside segment")
  `SEG_PICK_ASSERT_NXT(a_stall_holds, !en, $stable(a_valid_q) && $stable(r_valid_q), "pipeline moved while stalled")

endmodule
